// ===== design/point_in_polygon_winding_unit_assert.svh =====
// ----------------------------------------------------------------------------
// point_in_polygon_winding_unit assertion macros
// shared property forms, clocked on i_clk and held off while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef POINT_IN_POLYGON_WINDING_UNIT_ASSERT_SVH
`define POINT_IN_POLYGON_WINDING_UNIT_ASSERT_SVH

// same-cycle implication
`define PIPW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PIPW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/pipw_pkg.sv =====
// ----------------------------------------------------------------------------
// pipw_pkg
// shared types, constants and the cordic arctangent table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pipw_pkg;

    // width of the cordic datapath, fixed by the normalization target
    localparam int CORDIC_W  = 64;
    localparam int NORM_TOP  = 56;
    localparam int NORM_STEP = 8;
    localparam int CORD_ITER = 32;

    // classification of one queued word
    typedef struct packed {
        logic first;
        logic last;
        logic skip;
        logic box;
    } t_pipw_flags;

    // atan(2^-i) in 2^-32 turn
    function automatic logic [31:0] atan_turn32(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/pipw_front.sv =====
// ----------------------------------------------------------------------------
// pipw_front
// takes input words, forms the edge vectors relative to the point and
// classifies each word before it is queued
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pipw_front #(
    parameter int COORD_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_BITS-1:0]  i_point_x,
    input  logic signed [COORD_BITS-1:0]  i_point_y,
    input  logic signed [COORD_BITS-1:0]  i_vertex_x,
    input  logic signed [COORD_BITS-1:0]  i_vertex_y,
    input  logic signed [COORD_BITS-1:0]  i_box_x_min,
    input  logic signed [COORD_BITS-1:0]  i_box_x_max,
    input  logic signed [COORD_BITS-1:0]  i_box_y_min,
    input  logic signed [COORD_BITS-1:0]  i_box_y_max,
    input  logic                          i_first_vertex,
    input  logic                          i_last_vertex,
    input  logic                          i_q_full,
    output logic                          o_q_push,
    output logic signed [COORD_BITS:0]    o_ux,
    output logic signed [COORD_BITS:0]    o_uy,
    output logic signed [COORD_BITS:0]    o_vx,
    output logic signed [COORD_BITS:0]    o_vy,
    output pipw_pkg::t_pipw_flags         o_flags
);
    import pipw_pkg::*;

    logic signed [COORD_BITS-1:0] r_prev_x;
    logic signed [COORD_BITS-1:0] r_prev_y;
    logic                         zero_u;
    logic                         zero_v;
    logic                         box_ok;

    assign o_stall  = i_q_full;
    assign o_q_push = i_valid && !i_q_full;

    // vectors from the point to both edge ends, exact
    assign o_ux = {r_prev_x[COORD_BITS-1], r_prev_x} - {i_point_x[COORD_BITS-1], i_point_x};
    assign o_uy = {r_prev_y[COORD_BITS-1], r_prev_y} - {i_point_y[COORD_BITS-1], i_point_y};
    assign o_vx = {i_vertex_x[COORD_BITS-1], i_vertex_x} - {i_point_x[COORD_BITS-1], i_point_x};
    assign o_vy = {i_vertex_y[COORD_BITS-1], i_vertex_y} - {i_point_y[COORD_BITS-1], i_point_y};

    // degenerate edges and half-open box test
    assign zero_u = (o_ux == '0) && (o_uy == '0);
    assign zero_v = (o_vx == '0) && (o_vy == '0);
    assign box_ok = (i_point_x >= i_box_x_min) && (i_point_x < i_box_x_max)
                 && (i_point_y >= i_box_y_min) && (i_point_y < i_box_y_max);

    always_comb begin
        o_flags.first = i_first_vertex;
        o_flags.last  = i_last_vertex;
        o_flags.skip  = i_first_vertex || zero_u || zero_v;
        o_flags.box   = box_ok;
    end

    // previous vertex
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_x <= '0;
            r_prev_y <= '0;
        end else if (o_q_push) begin
            r_prev_x <= i_vertex_x;
            r_prev_y <= i_vertex_y;
        end
    end

endmodule

// ===== design/pipw_fifo.sv =====
// ----------------------------------------------------------------------------
// pipw_fifo
// two-entry queue between the front and the back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pipw_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);
    import pipw_pkg::*;

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, do_pop};
        end
    end

endmodule

// ===== design/pipw_back.sv =====
// ----------------------------------------------------------------------------
// pipw_back
// sequential angle unit: normalizes each vector, runs cordic vectoring one
// step a cycle, accumulates edge angles and forms the winding result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "point_in_polygon_winding_unit_assert.svh"

module pipw_back #(
    parameter int COORD_BITS = 32,
    parameter int ANGLE_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    output logic                        o_q_pop,
    input  logic signed [COORD_BITS:0]  i_ux,
    input  logic signed [COORD_BITS:0]  i_uy,
    input  logic signed [COORD_BITS:0]  i_vx,
    input  logic signed [COORD_BITS:0]  i_vy,
    input  pipw_pkg::t_pipw_flags       i_flags,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_inside_res,
    output logic signed [7:0]           o_winding,
    output logic                        o_in_box
);
    import pipw_pkg::*;

    localparam int EXT = CORDIC_W - COORD_BITS - 1;
    localparam logic signed [CORDIC_W-1:0] LIM_STEP = 64'sd1 <<< (NORM_TOP - NORM_STEP);
    localparam logic signed [CORDIC_W-1:0] LIM_TOP  = 64'sd1 <<< NORM_TOP;
    localparam logic [31:0] ROUND_ADD = 32'd1 << (31 - ANGLE_BITS);
    localparam logic [ANGLE_BITS-1:0] HALF = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
    localparam logic [32:0] TURN_RND = 33'd1 << (ANGLE_BITS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_NORM,
        S_CORD,
        S_ACC,
        S_EMIT
    } t_state;

    t_state                     r_state;
    logic signed [CORDIC_W-1:0] r_x;
    logic signed [CORDIC_W-1:0] r_y;
    logic [31:0]                r_z;
    logic [4:0]                 r_i;
    logic                       r_sel;
    logic [ANGLE_BITS-1:0]      r_a_u;
    logic signed [COORD_BITS:0] r_vx;
    logic signed [COORD_BITS:0] r_vy;
    t_pipw_flags                r_flags;
    logic signed [ANGLE_BITS:0] r_delta;
    logic signed [31:0]         r_sum;
    logic                       r_box_hit;
    logic                       r_out_valid;
    logic                       r_out_inside;
    logic signed [7:0]          r_out_winding;
    logic                       r_out_box;

    logic                       small_step;
    logic                       small_top;
    logic signed [CORDIC_W-1:0] xs;
    logic signed [CORDIC_W-1:0] ys;
    logic signed [CORDIC_W-1:0] n_x;
    logic signed [CORDIC_W-1:0] n_y;
    logic [31:0]                n_z;
    logic [31:0]                z_rnd;
    logic [ANGLE_BITS-1:0]      ang;
    logic [ANGLE_BITS-1:0]      d_ang;
    logic signed [ANGLE_BITS:0] n_delta;
    logic signed [32:0]         sum_wide;
    logic signed [31:0]         n_sum;
    logic [31:0]                mag;
    logic [32:0]                turns;
    logic [6:0]                 turns_sat;
    logic signed [7:0]          n_winding;
    logic                       out_free;

    assign o_q_pop      = (r_state == S_IDLE) && i_q_valid;
    assign o_valid      = r_out_valid;
    assign o_inside_res = r_out_inside;
    assign o_winding    = r_out_winding;
    assign o_in_box     = r_out_box;
    assign out_free     = !r_out_valid || !i_stall;

    // magnitude checks for normalization
    assign small_step = (r_x < LIM_STEP) && (r_x > -LIM_STEP)
                     && (r_y < LIM_STEP) && (r_y > -LIM_STEP);
    assign small_top  = (r_x < LIM_TOP) && (r_x > -LIM_TOP)
                     && (r_y < LIM_TOP) && (r_y > -LIM_TOP);

    // one cordic vectoring step
    always_comb begin
        xs = r_x >>> r_i;
        ys = r_y >>> r_i;
        if (!r_y[CORDIC_W-1]) begin
            n_x = r_x + ys;
            n_y = r_y - xs;
            n_z = r_z + atan_turn32(r_i);
        end else begin
            n_x = r_x - ys;
            n_y = r_y + xs;
            n_z = r_z - atan_turn32(r_i);
        end
        z_rnd = n_z + ROUND_ADD;
        ang   = z_rnd[31 -: ANGLE_BITS];
    end

    // edge angle wrapped to (-half, +half]
    always_comb begin
        d_ang   = ang - r_a_u;
        n_delta = (d_ang > HALF) ? {1'b1, d_ang} : {1'b0, d_ang};
    end

    // saturating accumulate
    always_comb begin
        sum_wide = {r_sum[31], r_sum} + {{(32 - ANGLE_BITS){r_delta[ANGLE_BITS]}}, r_delta};
        if (sum_wide > 33'sd2147483647) begin
            n_sum = 32'sh7fff_ffff;
        end else if (sum_wide < -33'sd2147483648) begin
            n_sum = 32'sh8000_0000;
        end else begin
            n_sum = sum_wide[31:0];
        end
    end

    // rounded turns, saturated
    always_comb begin
        mag       = r_sum[31] ? (32'd0 - r_sum) : r_sum;
        turns     = ({1'b0, mag} + TURN_RND) >> ANGLE_BITS;
        turns_sat = (turns > 33'd127) ? 7'd127 : turns[6:0];
        n_winding = r_sum[31] ? (8'sd0 - {1'b0, turns_sat}) : {1'b0, turns_sat};
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum       <= '0;
            r_box_hit   <= 1'b0;
            r_out_valid <= 1'b0;
            r_i         <= '0;
            r_sel       <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_flags <= i_flags;
                        r_vx    <= i_vx;
                        r_vy    <= i_vy;
                        r_x     <= {{EXT{i_ux[COORD_BITS]}}, i_ux};
                        r_y     <= {{EXT{i_uy[COORD_BITS]}}, i_uy};
                        r_sel   <= 1'b0;
                        if (i_flags.first) begin
                            r_sum     <= '0;
                            r_box_hit <= i_flags.box;
                        end
                        if (i_flags.skip) begin
                            r_delta <= '0;
                            r_state <= S_ACC;
                        end else begin
                            r_state <= S_NORM;
                        end
                    end
                end
                S_NORM: begin
                    if (small_step) begin
                        r_x <= r_x <<< NORM_STEP;
                        r_y <= r_y <<< NORM_STEP;
                    end else if (small_top) begin
                        r_x <= r_x <<< 1;
                        r_y <= r_y <<< 1;
                    end else begin
                        // fold into the right half plane
                        if (r_x[CORDIC_W-1]) begin
                            r_x <= -r_x;
                            r_y <= -r_y;
                            r_z <= 32'h8000_0000;
                        end else begin
                            r_z <= '0;
                        end
                        r_i     <= '0;
                        r_state <= S_CORD;
                    end
                end
                S_CORD: begin
                    r_z <= n_z;
                    r_i <= r_i + 5'd1;
                    if ((r_i == 5'(CORD_ITER - 1)) && !r_sel) begin
                        // start direction done, load the end vector
                        r_a_u   <= ang;
                        r_x     <= {{EXT{r_vx[COORD_BITS]}}, r_vx};
                        r_y     <= {{EXT{r_vy[COORD_BITS]}}, r_vy};
                        r_sel   <= 1'b1;
                        r_state <= S_NORM;
                    end else begin
                        r_x <= n_x;
                        r_y <= n_y;
                        if (r_i == 5'(CORD_ITER - 1)) begin
                            r_delta <= n_delta;
                            r_state <= S_ACC;
                        end
                    end
                end
                S_ACC: begin
                    r_sum   <= n_sum;
                    r_state <= r_flags.last ? S_EMIT : S_IDLE;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_winding <= n_winding;
                        r_out_box     <= r_box_hit;
                        r_out_inside  <= r_box_hit && (n_winding != 8'sd0);
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // checks
    `PIPW_ASSERT_NOW(a_cord_right_half, (r_state == S_CORD) && (r_i == 5'd0), !r_x[CORDIC_W-1], "cordic started in left half plane")
    `PIPW_ASSERT_NOW(a_wind_sat, r_out_valid, r_out_winding != -8'sd128, "winding beyond saturation")
    `PIPW_ASSERT_NOW(a_inside_box, r_out_valid && r_out_inside, r_out_box, "inside without box hit")
    `PIPW_ASSERT_NEXT(a_first_clears, o_q_pop && i_flags.first, r_sum == 32'sd0, "sum not cleared on first vertex")

endmodule

// ===== design/point_in_polygon_winding_unit.sv =====
// ----------------------------------------------------------------------------
// point_in_polygon_winding_unit
// winding-number point-in-polygon test over a stream of polygon vertices
//
//   channel  direction  handshake            fields
//   input    in         i_valid / o_stall    point, vertex, box, first, last
//   result   out        o_valid / i_stall    inside_res, winding, in_box
//
// in the back an edge takes two normalizations of up to about 15 steps and
// two 32-step cordic runs on one shared datapath.
// a first vertex or a degenerate edge skips both; a result adds an emit step.
// the front and back are parted by a two-entry queue, so input words are
// taken while the back works or a result waits on a stalled output.
// reset is synchronous, active low, and clears the previous vertex and sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module point_in_polygon_winding_unit #(
    parameter int COORD_BITS = 32,
    parameter int ANGLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_BITS-1:0]  i_point_x,
    input  logic signed [COORD_BITS-1:0]  i_point_y,
    input  logic signed [COORD_BITS-1:0]  i_vertex_x,
    input  logic signed [COORD_BITS-1:0]  i_vertex_y,
    input  logic signed [COORD_BITS-1:0]  i_box_x_min,
    input  logic signed [COORD_BITS-1:0]  i_box_x_max,
    input  logic signed [COORD_BITS-1:0]  i_box_y_min,
    input  logic signed [COORD_BITS-1:0]  i_box_y_max,
    input  logic                          i_first_vertex,
    input  logic                          i_last_vertex,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_inside_res,
    output logic signed [7:0]             o_winding,
    output logic                          o_in_box
);
    import pipw_pkg::*;

    localparam int VW = COORD_BITS + 1;
    localparam int QW = 4 * VW + $bits(t_pipw_flags);

    logic                 q_full;
    logic                 q_push;
    logic                 q_valid;
    logic                 q_pop;
    logic [QW-1:0]        q_wdata;
    logic [QW-1:0]        q_rdata;
    logic signed [VW-1:0] f_ux;
    logic signed [VW-1:0] f_uy;
    logic signed [VW-1:0] f_vx;
    logic signed [VW-1:0] f_vy;
    t_pipw_flags          f_flags;
    t_pipw_flags          b_flags;

    // front: vectors and classification
    pipw_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_vertex_x     (i_vertex_x),
        .i_vertex_y     (i_vertex_y),
        .i_box_x_min    (i_box_x_min),
        .i_box_x_max    (i_box_x_max),
        .i_box_y_min    (i_box_y_min),
        .i_box_y_max    (i_box_y_max),
        .i_first_vertex (i_first_vertex),
        .i_last_vertex  (i_last_vertex),
        .i_q_full       (q_full),
        .o_q_push       (q_push),
        .o_ux           (f_ux),
        .o_uy           (f_uy),
        .o_vx           (f_vx),
        .o_vy           (f_vy),
        .o_flags        (f_flags)
    );

    // queue word packing
    assign q_wdata = {f_ux, f_uy, f_vx, f_vy, f_flags};
    assign b_flags = t_pipw_flags'(q_rdata[$bits(t_pipw_flags)-1:0]);

    pipw_fifo #(
        .WIDTH (QW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_rdata)
    );

    // back: angle unit and accumulator
    pipw_back #(
        .COORD_BITS (COORD_BITS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .o_q_pop      (q_pop),
        .i_ux         (q_rdata[QW-1 -: VW]),
        .i_uy         (q_rdata[QW-VW-1 -: VW]),
        .i_vx         (q_rdata[QW-2*VW-1 -: VW]),
        .i_vy         (q_rdata[QW-3*VW-1 -: VW]),
        .i_flags      (b_flags),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_inside_res (o_inside_res),
        .o_winding    (o_winding),
        .o_in_box     (o_in_box)
    );

endmodule

// ===== verif/point_in_polygon_winding_unit_test.sv =====
// ----------------------------------------------------------------------------
// point_in_polygon_winding_unit_test
// self-checking bench for the winding-number point-in-polygon unit: polygons
// are streamed one vertex word at a time, a scoreboard class predicts the
// winding and box flags with its own cordic bearing model, and both channels
// idle and stall at random, with one long output hold-off
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module point_in_polygon_winding_unit_test;

    localparam int WORD_TARGET  = 1750;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 250;
    localparam int HOLD_CYCLES  = 500;
    localparam int HOLD_AT      = 400;
    localparam int UNIT         = 1 << 22;
    localparam longint SUM_MAX  = 64'sd2147483647;
    localparam longint SUM_MIN  = -64'sd2147483648;

    // one input word
    typedef struct {
        logic signed [31:0] px, py, vx, vy, bx0, bx1, by0, by1;
        logic               first, last;
    } t_vertex_word;

    // one result word
    typedef struct {
        logic              inside_res;
        logic signed [7:0] winding;
        logic              in_box;
    } t_winding_word;

    // winding predictor and store of expected result words
    class winding_board;
        t_winding_word pending[$];
        longint        prev_x, prev_y, angle_sum;
        logic          box_hit;
        int            mismatches, results_seen;
        logic [31:0]   atan_turn[32];

        function new();
            atan_turn = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
                          32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
                          32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
                          32'd166886, 32'd83443, 32'd41722, 32'd20861, 32'd10430,
                          32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
                          32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1,
                          32'd1, 32'd0};
            prev_x = 0;
            prev_y = 0;
            angle_sum = 0;
            box_hit = 0;
            mismatches = 0;
            results_seen = 0;
        endfunction

        // direction of a nonzero vector in 2^-16 turn
        function logic [15:0] bearing(longint dx, longint dy);
            longint      ax, ay, m, x, y, xs, ys;
            int          s;
            logic [31:0] z;
            logic [32:0] q;
            ax = dx < 0 ? -dx : dx;
            ay = dy < 0 ? -dy : dy;
            m = ax > ay ? ax : ay;
            s = 0;
            while ((m << s) < (64'sd1 << 56))
                s++;
            x = dx <<< s;
            y = dy <<< s;
            z = 0;
            if (x < 0) begin
                x = -x;
                y = -y;
                z = 32'h8000_0000;
            end
            for (int i = 0; i < 32; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0) begin
                    x += ys;
                    y -= xs;
                    z += atan_turn[i];
                end else begin
                    x -= ys;
                    y += xs;
                    z -= atan_turn[i];
                end
            end
            q = {1'b0, z} + (33'd1 << 15);
            return q[31:16];
        endfunction

        // signed angle of one edge seen from the point, in (-half, +half]
        function longint edge_turn(longint px, longint py, longint bx, longint by);
            longint      ux, uy, wx, wy;
            logic [15:0] d;
            ux = prev_x - px;
            uy = prev_y - py;
            wx = bx - px;
            wy = by - py;
            if ((ux == 0 && uy == 0) || (wx == 0 && wy == 0))
                return 0;
            d = bearing(wx, wy) - bearing(ux, uy);
            return d > 16'h8000 ? longint'(d) - 65536 : longint'(d);
        endfunction

        // note an accepted vertex word
        function void note(t_vertex_word w);
            longint        s, mag, turns;
            t_winding_word r;
            if (w.first) begin
                angle_sum = 0;
                box_hit = w.px >= w.bx0 && w.px < w.bx1 && w.py >= w.by0 && w.py < w.by1;
            end else begin
                s = angle_sum + edge_turn(w.px, w.py, w.vx, w.vy);
                if (s > SUM_MAX) s = SUM_MAX;
                if (s < SUM_MIN) s = SUM_MIN;
                angle_sum = s;
            end
            prev_x = w.vx;
            prev_y = w.vy;
            if (w.last) begin
                mag = angle_sum < 0 ? -angle_sum : angle_sum;
                turns = (mag + 32768) >> 16;
                if (turns > 127) turns = 127;
                r.winding = 8'(angle_sum < 0 ? -turns : turns);
                r.in_box = box_hit;
                r.inside_res = box_hit && r.winding != 0;
                pending.push_back(r);
            end
        endfunction

        // check one result word against the oldest expectation
        function void check(t_winding_word got);
            t_winding_word want;
            results_seen++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: winding %0d in_box %0b inside %0b",
                             got.winding, got.in_box, got.inside_res);
                return;
            end
            want = pending.pop_front();
            if (got.inside_res !== want.inside_res || got.winding !== want.winding ||
                got.in_box !== want.in_box) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d mismatch: exp w %0d box %0b in %0b, got w %0d box %0b in %0b",
                             results_seen, want.winding, want.in_box, want.inside_res,
                             got.winding, got.in_box, got.inside_res);
            end
        endfunction
    endclass

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_valid = 0;
    logic               o_stall;
    logic signed [31:0] i_point_x = 0, i_point_y = 0, i_vertex_x = 0, i_vertex_y = 0;
    logic signed [31:0] i_box_x_min = 0, i_box_x_max = 0, i_box_y_min = 0, i_box_y_max = 0;
    logic               i_first_vertex = 0, i_last_vertex = 0;
    logic               o_valid;
    logic               i_stall = 0;
    logic               o_inside_res;
    logic signed [7:0]  o_winding;
    logic               o_in_box;

    winding_board board = new();
    int   words_in = 0;
    int   polygons = 0;
    int   idle_cycles = 0;
    bit   held_off = 0;
    bit   send_burst = 0;

    point_in_polygon_winding_unit dut (.*);

    always #6 i_clk = ~i_clk;

    // gap length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // offer one word and wait for it to be taken
    task automatic offer(t_vertex_word w);
        int gap;
        i_valid <= 1;
        i_point_x <= w.px;
        i_point_y <= w.py;
        i_vertex_x <= w.vx;
        i_vertex_y <= w.vy;
        i_box_x_min <= w.bx0;
        i_box_x_max <= w.bx1;
        i_box_y_min <= w.by0;
        i_box_y_max <= w.by1;
        i_first_vertex <= w.first;
        i_last_vertex <= w.last;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        board.note(w);
        words_in++;
        if (words_in % 150 == 0)
            send_burst = ~send_burst;
        gap = send_burst ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // word from a point, a vertex, a box and the two marks
    function automatic t_vertex_word mk(int px, int py, int vx, int vy,
                                        int bx0, int bx1, int by0, int by1,
                                        bit first, bit last);
        t_vertex_word w;
        w.px = px; w.py = py; w.vx = vx; w.vy = vy;
        w.bx0 = bx0; w.bx1 = bx1; w.by0 = by0; w.by1 = by1;
        w.first = first; w.last = last;
        return w;
    endfunction

    // polygon winding `loops` times around (cx, cy), closed when loops is nonzero, point near or far
    task automatic send_polygon(int loops, int per_loop, bit far_point, bit broken);
        int           cx, cy, rad, px, py, n, bx0, bx1, by0, by1, mode;
        real          ang, dir;
        t_vertex_word w;
        cx = $urandom_range(0, 1 << 30) - (1 << 29);
        cy = $urandom_range(0, 1 << 30) - (1 << 29);
        rad = $urandom_range(8, 1 << 28);
        dir = ($urandom_range(0, 1) ? 1.0 : -1.0);
        px = cx + (far_point ? 3 * rad : $urandom_range(0, rad / 4) - rad / 8);
        py = cy + $urandom_range(0, rad / 4) - rad / 8;
        n = loops * per_loop;
        mode = $urandom_range(0, 5);
        bx0 = px - $urandom_range(0, 1 << 20);
        bx1 = px + $urandom_range(1, 1 << 20);
        by0 = py - $urandom_range(0, 1 << 20);
        by1 = py + $urandom_range(1, 1 << 20);
        // half-open edges of the box
        if (mode == 0) bx0 = px;
        if (mode == 1) bx1 = px;
        if (mode == 2) by0 = py;
        if (mode == 3) by1 = py;
        if (loops == 0) n = per_loop;
        for (int k = 0; k <= n; k++) begin
            ang = dir * 6.283185307179586 * (k % (loops == 0 ? 1 : n)) / per_loop;
            if (loops == 0)
                ang = 0.5 * dir * $sin(1.0 * k);
            w = mk(px, py, cx + $rtoi(rad * $cos(ang)), cy + $rtoi(rad * $sin(ang)),
                   bx0, bx1, by0, by1, k == 0, k == n);
            if (broken && k == 0 && $urandom_range(0, 1)) w.first = 0;
            if (broken && k == n && $urandom_range(0, 1)) w.last = 0;
            offer(w);
        end
        polygons++;
    endtask

    // directed words: extremes and special cases
    task automatic send_directed();
        int u;
        u = UNIT;
        // no first mark right after reset: chains from the origin
        offer(mk(u, 0, 0, u, 0, 0, 0, 0, 0, 1));
        // first and last together inside the box
        offer(mk(0, 0, u, u, -u, u, -u, u, 1, 1));
        // exact half turns through the point
        offer(mk(0, 0, -u, 0, -u, u, -u, u, 1, 0));
        offer(mk(0, 0, u, 0, 0, 0, 0, 0, 0, 0));
        offer(mk(0, 0, -u, 0, 0, 0, 0, 0, 0, 1));
        // point on vertices: degenerate edges
        offer(mk(5, 5, 5, 5, 0, 10, 0, 10, 1, 0));
        offer(mk(5, 5, 10, 0, 0, 0, 0, 0, 0, 0));
        offer(mk(5, 5, 5, 5, 0, 0, 0, 0, 0, 1));
        // full-range corners, point on the exclusive box edge
        offer(mk(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 1, 0));
        offer(mk(0, 0, 32'h7fffffff, 32'h80000000, 0, 0, 0, 0, 0, 0));
        offer(mk(-1, 1, 32'h7fffffff, 32'h7fffffff, 0, 0, 0, 0, 0, 0));
        offer(mk(32'h80000000, 0, 32'h80000000, 32'h7fffffff, 0, 0, 0, 0, 0, 0));
        offer(mk(0, 0, 32'h80000000, 32'h80000000, 0, 0, 0, 0, 0, 1));
        // point on the inclusive box edge, changing point per edge
        offer(mk(-u, -u, 3 * u, 0, -u, u, -u, u, 1, 0));
        offer(mk(1, 2, 0, 3 * u, 0, 0, 0, 0, 0, 0));
        offer(mk(-2, 1, -3 * u, -3 * u, 0, 0, 0, 0, 0, 0));
        offer(mk(0, -1, 3 * u, 0, 0, 0, 0, 0, 0, 1));
        // continuing after a last vertex without a first mark
        offer(mk(0, 0, 0, -u, 0, 0, 0, 0, 0, 1));
    endtask

    // random word with random marks
    function automatic t_vertex_word noise_word();
        t_vertex_word w;
        w = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom_range(0, 1), $urandom_range(0, 3) == 0);
        if ($urandom_range(0, 7) == 0) begin
            w.vx = w.px;
            w.vy = w.py;
        end
        return w;
    endfunction

    // result side: check accepted words, stall at random, one long hold-off
    initial begin : result_side
        int  stall_left;
        int  hold_left;
        bit  rx_burst;
        t_winding_word got;
        stall_left = 0;
        hold_left = 0;
        rx_burst = 0;
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall) begin
                got.inside_res = o_inside_res;
                got.winding = o_winding;
                got.in_box = o_in_box;
                board.check(got);
                if (board.results_seen % 40 == 0)
                    rx_burst = ~rx_burst;
            end
            if (!held_off && words_in >= HOLD_AT) begin
                held_off = 1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1;
            end else begin
                stall_left = rx_burst ? 0 : pick_gap();
                i_stall <= stall_left > 0;
                if (stall_left > 0) stall_left--;
            end
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
                $display("point_in_polygon_winding_unit_test: done, errors");
                $finish;
            end
        end
    end

    // stimulus and end of run
    initial begin : stimulus
        int r;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        send_directed();
        // one long polygon pushes the winding into saturation
        send_polygon(130, 4, 0, 0);
        while (words_in < WORD_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 10)
                offer(noise_word());
            else if (r < 20)
                send_polygon(0, $urandom_range(2, 6), 0, 0);
            else
                send_polygon($urandom_range(1, 3), $urandom_range(3, 8),
                             $urandom_range(0, 4) == 0, $urandom_range(0, 9) == 0);
        end
        i_valid <= 0;
        while (board.pending.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d vertex words in %0d polygons, %0d results, %0d mismatches",
                 words_in, polygons, board.results_seen, board.mismatches);
        $display("with random gaps on both sides and a %0d-cycle output hold-off",
                 HOLD_CYCLES);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("point_in_polygon_winding_unit_test: done, clean");
        else
            $display("point_in_polygon_winding_unit_test: done, errors");
        $finish;
    end

endmodule
